// File: hw/rtl/tps_pkg.sv
// Shared types, constants and corner helpers for the triangle position solver.
// Used by the channel interfaces and by triangle_position_solver.
package tps_pkg;

  typedef logic [31:0] msg_word_t;
  typedef logic [9:0]  dist_t;
  typedef logic [15:0] word16_t;
  typedef logic [1:0]  corner_t;
  typedef logic [1:0]  status_t;
  typedef logic [1:0]  cfg_index_t;
  typedef logic [9:0]  cfg_data_t;
  typedef logic [4:0]  iter_t;

  // Configuration register indexes.
  localparam cfg_index_t REG_MY_CORNER    = 2'd0;
  localparam cfg_index_t REG_SIDE_LENGTH  = 2'd1;
  localparam cfg_index_t REG_TOTAL_HEIGHT = 2'd2;

  localparam corner_t CORNER_FIRST = 2'd0;
  localparam corner_t CORNER_LAST  = 2'd2;

  localparam logic [1:0]  RESET_MY_CORNER    = 2'd0;
  localparam logic [9:0]  RESET_SIDE_LENGTH  = 10'd1023;
  localparam logic [9:0]  RESET_TOTAL_HEIGHT = 10'd886;

  localparam word16_t     AREA_SCALE  = 16'hFFFF;
  localparam logic [30:0] SQ_BIT_INIT = 31'h4000_0000;
  localparam iter_t       DIV_LAST    = 5'd31;
  localparam iter_t       SQRT_LAST   = 5'd15;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SLSQ,
    ST_SLSQ_W,
    ST_AB_DL,
    ST_AB_DR,
    ST_AB_SUB,
    ST_AH_D2,
    ST_AH_B2,
    ST_AH_SUB,
    ST_ADJ,
    ST_CB_MUL,
    ST_CB_DIV,
    ST_CH_A,
    ST_CH_B,
    ST_CH_C,
    ST_AR_MUL,
    ST_AR_DIV,
    ST_DIV,
    ST_DIV_END,
    ST_SQRT,
    ST_SQ_END,
    ST_DONE
  } state_t;

  // Destination of the shared divide or square root unit.
  typedef enum logic [2:0] {
    JOB_AB,
    JOB_AH,
    JOB_CB,
    JOB_CH,
    JOB_AREA
  } job_t;

  typedef struct packed {
    status_t status_bits;
    word16_t base_left;
    word16_t base_mine;
    word16_t base_right;
    word16_t height_left;
    word16_t height_mine;
    word16_t height_right;
    word16_t collinear_base;
    word16_t collinear_height;
    word16_t area_fraction;
    logic    divide_by_zero;
  } result_t;

  function automatic corner_t left_of(corner_t c);
    return (c < CORNER_LAST) ? corner_t'(c + 2'd1) : CORNER_FIRST;
  endfunction

  function automatic corner_t right_of(corner_t c);
    return (c > CORNER_FIRST) ? corner_t'(c - 2'd1) : CORNER_LAST;
  endfunction

endpackage

// File: hw/rtl/tps_msg_if.sv
// Input channel carrying one packed message word per transaction.
// Depends on tps_pkg.
interface tps_msg_if import tps_pkg::*; ();
  logic      valid;
  logic      ready;
  msg_word_t message_word;

  modport source (output valid, output message_word, input ready);
  modport sink   (input valid, input message_word, output ready);
endinterface

// File: hw/rtl/tps_res_if.sv
// Result channel carrying the status, solved bases, heights, collinear terms, area fraction and divide-by-zero flag.
// Depends on tps_pkg.
interface tps_res_if import tps_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status_bits;
  word16_t base_left;
  word16_t base_mine;
  word16_t base_right;
  word16_t height_left;
  word16_t height_mine;
  word16_t height_right;
  word16_t collinear_base;
  word16_t collinear_height;
  word16_t area_fraction;
  logic    divide_by_zero;

  modport source (
    output valid, output status_bits, output base_left, output base_mine,
    output base_right, output height_left, output height_mine, output height_right,
    output collinear_base, output collinear_height, output area_fraction,
    output divide_by_zero, input ready
  );
  modport sink (
    input valid, input status_bits, input base_left, input base_mine,
    input base_right, input height_left, input height_mine, input height_right,
    input collinear_base, input collinear_height, input area_fraction,
    input divide_by_zero, output ready
  );
endinterface

// File: hw/rtl/tps_cfg_if.sv
// Configuration write channel: register index and write data per transaction.
// Depends on tps_pkg.
interface tps_cfg_if import tps_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/triangle_position_solver.sv
// Triangle position solver: one shared multiplier and one shared compare/subtract
// unit, run by a sequencer, for 32-step restoring divides and 16-step square roots.
// Each input transaction runs five divides and up to four square roots, one after
// another in the unit, before its result is valid.
// One item at a time; the next one is taken while the finished result waits.
// Synchronous reset: sequencer idle, no result pending, config registers at reset values.
module triangle_position_solver import tps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tps_cfg_if.sink     cfg,
  tps_msg_if.sink     request,
  tps_res_if.source   result
);

  state_t      state;
  state_t      state_next;
  job_t        job;

  logic [1:0]  my_corner;
  logic [9:0]  side_length;
  logic [9:0]  total_height;

  status_t     status;
  dist_t       distance [3];
  word16_t     ab [3];
  word16_t     ah [3];
  corner_t     mine;
  corner_t     corner;
  logic [19:0] sl_sq;
  logic [31:0] acc;
  logic [31:0] prod;
  logic [16:0] rem;
  logic [16:0] div_d;
  logic [16:0] hsum;
  logic [31:0] res;
  logic [30:0] sq_bit;
  iter_t       iter;
  word16_t     diff;
  word16_t     cb;
  word16_t     ch;
  word16_t     area;
  logic        dz;
  result_t     held;
  logic        pending;

  word16_t     mul_a;
  word16_t     mul_b;
  logic [31:0] mul_out;
  logic [32:0] sub_a;
  logic [32:0] sub_b;
  logic [32:0] sub_diff;
  logic        sub_ge;
  logic        load_result;

  corner_t     lft;
  corner_t     rgt;
  corner_t     corner_inc;
  logic        ab_over;
  logic [31:0] res_step;
  word16_t     root;
  word16_t     quotient;
  logic [17:0] hsum3;
  word16_t     th_diff;
  word16_t     delta;

  assign lft        = left_of(mine);
  assign rgt        = right_of(mine);
  assign corner_inc = (corner == CORNER_LAST) ? CORNER_FIRST : corner_t'(corner + 2'd1);
  assign ab_over    = ab[corner] > {6'b0, distance[right_of(corner)]};

  assign mul_out  = {16'b0, mul_a} * {16'b0, mul_b};
  assign sub_diff = sub_a - sub_b;
  assign sub_ge   = ~sub_diff[32];

  // In the rounding state the shared unit computes res - acc; a borrow means acc > res and rounds the root up.
  assign root     = sub_diff[32] ? word16_t'(res[15:0] + 16'd1) : res[15:0];
  assign res_step = sub_ge ? (res + {sq_bit, 1'b0}) : res;
  assign quotient = (div_d == '0) ? '0 : acc[15:0];

  assign hsum3   = {2'b0, ah[0]} + {2'b0, ah[1]} + {2'b0, ah[2]};
  assign th_diff = {6'b0, total_height} - hsum3[15:0];
  assign delta   = {1'b0, th_diff[15:1]};

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      my_corner    <= RESET_MY_CORNER;
      side_length  <= RESET_SIDE_LENGTH;
      total_height <= RESET_TOTAL_HEIGHT;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MY_CORNER:    my_corner    <= cfg.data[1:0];
        REG_SIDE_LENGTH:  side_length  <= cfg.data;
        REG_TOTAL_HEIGHT: total_height <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 1'b0;
    end else begin
      state <= state_next;
      if (load_result) begin
        pending <= 1'b1;
      end else if (result.ready) begin
        pending <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (request.valid) state_next = ST_SLSQ;
      ST_SLSQ:    state_next = ST_SLSQ_W;
      ST_SLSQ_W:  state_next = ST_AB_DL;
      ST_AB_DL:   state_next = ST_AB_DR;
      ST_AB_DR:   state_next = ST_AB_SUB;
      ST_AB_SUB:  state_next = ST_DIV;
      ST_AH_D2: begin
        if (!ab_over) begin
          state_next = ST_AH_B2;
        end else if (corner == CORNER_LAST) begin
          state_next = ST_ADJ;
        end
      end
      ST_AH_B2:   state_next = ST_AH_SUB;
      ST_AH_SUB:  state_next = ST_SQRT;
      ST_ADJ:     state_next = ST_CB_MUL;
      ST_CB_MUL:  state_next = ST_CB_DIV;
      ST_CB_DIV:  state_next = ST_DIV;
      ST_CH_A:    state_next = ST_CH_B;
      ST_CH_B:    state_next = ST_CH_C;
      ST_CH_C:    state_next = ST_SQRT;
      ST_AR_MUL:  state_next = ST_AR_DIV;
      ST_AR_DIV:  state_next = ST_DIV;
      ST_DIV:     if (iter == '0) state_next = ST_DIV_END;
      ST_DIV_END: begin
        case (job)
          JOB_AB:   state_next = (corner == CORNER_LAST) ? ST_AH_D2 : ST_AB_DL;
          JOB_CB:   state_next = ST_CH_A;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_SQRT:    if (iter == '0) state_next = ST_SQ_END;
      ST_SQ_END: begin
        case (job)
          JOB_AH:   state_next = (corner == CORNER_LAST) ? ST_ADJ : ST_AH_D2;
          default:  state_next = ST_AR_MUL;
        endcase
      end
      ST_DONE:    if (!pending || result.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    request.ready = 1'b0;
    load_result   = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    sub_a         = '0;
    sub_b         = '0;
    case (state)
      ST_IDLE:   request.ready = 1'b1;
      ST_SLSQ: begin
        mul_a = {6'b0, side_length};
        mul_b = {6'b0, side_length};
      end
      ST_AB_DL: begin
        mul_a = {6'b0, distance[left_of(corner)]};
        mul_b = {6'b0, distance[left_of(corner)]};
      end
      ST_AB_DR, ST_AH_D2: begin
        mul_a = {6'b0, distance[right_of(corner)]};
        mul_b = {6'b0, distance[right_of(corner)]};
      end
      ST_AH_B2: begin
        mul_a = ab[corner];
        mul_b = ab[corner];
      end
      ST_CB_MUL: begin
        mul_a = ah[lft];
        mul_b = {6'b0, side_length};
      end
      ST_CH_A: begin
        mul_a = ah[mine];
        mul_b = ah[mine];
      end
      ST_CH_B: begin
        mul_a = diff;
        mul_b = diff;
      end
      ST_AR_MUL: begin
        mul_a = AREA_SCALE;
        mul_b = ah[mine];
      end
      ST_DIV: begin
        sub_a = {15'b0, rem, acc[31]};
        sub_b = {16'b0, div_d};
      end
      ST_SQRT: begin
        sub_a = {1'b0, acc};
        sub_b = {1'b0, res} + {2'b0, sq_bit};
      end
      ST_SQ_END: begin
        sub_a = {1'b0, res};
        sub_b = {1'b0, acc};
      end
      ST_DONE:   load_result = !pending || result.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (request.valid) begin
          status      <= request.message_word[31:30];
          distance[0] <= request.message_word[9:0];
          distance[1] <= request.message_word[19:10];
          distance[2] <= request.message_word[29:20];
          mine        <= (my_corner > CORNER_LAST) ? CORNER_FIRST : my_corner;
        end
      end
      ST_SLSQ:   prod <= mul_out;
      ST_SLSQ_W: begin
        sl_sq  <= prod[19:0];
        corner <= CORNER_FIRST;
      end
      ST_AB_DL:  prod <= mul_out;
      ST_AB_DR: begin
        acc  <= {12'b0, sl_sq} + prod;
        prod <= mul_out;
      end
      ST_AB_SUB: begin
        acc   <= acc - prod;
        rem   <= '0;
        div_d <= {6'b0, side_length, 1'b0};
        iter  <= DIV_LAST;
        job   <= JOB_AB;
      end
      ST_AH_D2: begin
        prod <= mul_out;
        // A base beyond the distance has no real altitude: height is zero.
        if (ab_over) begin
          ah[corner] <= '0;
          corner     <= corner_inc;
        end
      end
      ST_AH_B2: begin
        acc  <= prod;
        prod <= mul_out;
      end
      ST_AH_SUB: begin
        acc    <= acc - prod;
        res    <= '0;
        sq_bit <= SQ_BIT_INIT;
        iter   <= SQRT_LAST;
        job    <= JOB_AH;
      end
      ST_ADJ: begin
        for (int i = 0; i < 3; i++) begin
          if (ah[i] == '0) ah[i] <= delta;
        end
      end
      ST_CB_MUL: begin
        prod <= mul_out;
        hsum <= {1'b0, ah[lft]} + {1'b0, ah[rgt]};
      end
      ST_CB_DIV: begin
        acc   <= prod;
        div_d <= hsum;
        dz    <= (hsum == '0);
        rem   <= '0;
        iter  <= DIV_LAST;
        job   <= JOB_CB;
      end
      ST_CH_A: begin
        prod <= mul_out;
        diff <= (cb >= ab[mine]) ? word16_t'(cb - ab[mine]) : word16_t'(ab[mine] - cb);
      end
      ST_CH_B: begin
        acc  <= prod;
        prod <= mul_out;
      end
      ST_CH_C: begin
        acc    <= acc + prod;
        res    <= '0;
        sq_bit <= SQ_BIT_INIT;
        iter   <= SQRT_LAST;
        job    <= JOB_CH;
      end
      ST_AR_MUL: prod <= mul_out;
      ST_AR_DIV: begin
        acc   <= prod;
        div_d <= {7'b0, side_length};
        rem   <= '0;
        iter  <= DIV_LAST;
        job   <= JOB_AREA;
      end
      ST_DIV: begin
        // Restoring step: the quotient bit shifts into acc as the dividend shifts out.
        acc  <= {acc[30:0], sub_ge};
        rem  <= sub_ge ? sub_diff[16:0] : sub_a[16:0];
        iter <= iter - 5'd1;
      end
      ST_DIV_END: begin
        case (job)
          JOB_AB: begin
            ab[corner] <= quotient;
            corner     <= corner_inc;
          end
          JOB_CB:   cb   <= quotient;
          JOB_AREA: area <= quotient;
          default: ;
        endcase
      end
      ST_SQRT: begin
        if (sub_ge) acc <= sub_diff[31:0];
        res    <= res_step >> 1;
        sq_bit <= sq_bit >> 2;
        iter   <= iter - 5'd1;
      end
      ST_SQ_END: begin
        case (job)
          JOB_AH: begin
            ah[corner] <= root;
            corner     <= corner_inc;
          end
          JOB_CH:  ch <= root;
          default: ;
        endcase
      end
      ST_DONE: begin
        if (load_result) begin
          held.status_bits      <= status;
          held.base_left        <= ab[lft];
          held.base_mine        <= ab[mine];
          held.base_right       <= ab[rgt];
          held.height_left      <= ah[lft];
          held.height_mine      <= ah[mine];
          held.height_right     <= ah[rgt];
          held.collinear_base   <= cb;
          held.collinear_height <= ch;
          held.area_fraction    <= area;
          held.divide_by_zero   <= dz;
        end
      end
      default: ;
    endcase
  end

  assign result.valid            = pending;
  assign result.status_bits      = held.status_bits;
  assign result.base_left        = held.base_left;
  assign result.base_mine        = held.base_mine;
  assign result.base_right       = held.base_right;
  assign result.height_left      = held.height_left;
  assign result.height_mine      = held.height_mine;
  assign result.height_right     = held.height_right;
  assign result.collinear_base   = held.collinear_base;
  assign result.collinear_height = held.collinear_height;
  assign result.area_fraction    = held.area_fraction;
  assign result.divide_by_zero   = held.divide_by_zero;

endmodule
